// ===== sv/mpot_pkg.sv =====
// Shared types and constants for the masked priority opcode table.
// Used by mpot_cell and masked_priority_opcode_table_core; no dependencies.
package mpot_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int TAG_WIDTH_DEF   = 8;
  localparam int OP_W            = 16;
  localparam int FIELD_TAG_W     = 8;

  localparam logic KIND_REGISTER = 1'b0;
  localparam logic KIND_LOOKUP   = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic [OP_W-1:0]        code;
    logic [OP_W-1:0]        mask;
    logic [FIELD_TAG_W-1:0] action_tag;
    logic [OP_W-1:0]        opcode;
  } req_item_t;

  typedef struct packed {
    logic                   hit;
    logic [FIELD_TAG_W-1:0] matched_tag;
    logic                   status;
  } rsp_item_t;

  // Insert command broadcast to every cell of the chain.
  typedef struct packed {
    logic            en;
    logic [OP_W-1:0] code;
    logic [OP_W-1:0] mask;
  } ins_bus_t;

endpackage

// ===== sv/mpot_cell.sv =====
// One table cell: holds an entry, shifts on insert, and forwards the
// first-match result of the lookup chain. Depends on mpot_pkg.
module mpot_cell #(
  parameter int TAG_WIDTH = mpot_pkg::TAG_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mpot_pkg::ins_bus_t        ins,
  input  logic [TAG_WIDTH-1:0]      ins_tag,
  input  logic                      occupied,
  input  logic                      prev_keep,
  input  logic [mpot_pkg::OP_W-1:0] prev_code,
  input  logic [mpot_pkg::OP_W-1:0] prev_mask,
  input  logic [TAG_WIDTH-1:0]      prev_tag,
  input  logic [mpot_pkg::OP_W-1:0] opcode,
  input  logic                      prev_found,
  input  logic [TAG_WIDTH-1:0]      prev_found_tag,
  output logic                      keep,
  output logic [mpot_pkg::OP_W-1:0] code,
  output logic [mpot_pkg::OP_W-1:0] mask,
  output logic [TAG_WIDTH-1:0]      tag,
  output logic                      found,
  output logic [TAG_WIDTH-1:0]      found_tag
);

  logic match;

  // Entry stays put when it outranks the new one (ties keep the older entry).
  assign keep  = occupied && (mask >= ins.mask);
  assign match = occupied && ((opcode & mask) == code);

  always_ff @(posedge clk) begin
    if (ins.en && !keep) begin
      if (prev_keep) begin
        code <= ins.code;
        mask <= ins.mask;
        tag  <= ins_tag;
      end else begin
        code <= prev_code;
        mask <= prev_mask;
        tag  <= prev_tag;
      end
    end
  end

  // Advance the first-match result one cell per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= 1'b0;
      found_tag <= '0;
    end else if (prev_found) begin
      found     <= 1'b1;
      found_tag <= prev_found_tag;
    end else if (match) begin
      found     <= 1'b1;
      found_tag <= tag;
    end else begin
      found     <= 1'b0;
      found_tag <= '0;
    end
  end

endmodule

// ===== sv/masked_priority_opcode_table_core.sv =====
// Top level of the masked priority opcode table: a chain of mpot_cell.
// Depends on mpot_pkg and mpot_cell.
//
// A table of up to TABLE_DEPTH code/mask/tag entries, kept ordered by mask
// value, largest first; among equal masks the entry registered earlier
// stays ahead. A register item inserts its entry as it is taken: every cell
// compares its mask with the new one in parallel and the cells behind the
// insertion point shift one place down the chain. A register item to a
// full table leaves the table untouched and returns status 1. A lookup
// item holds its opcode while a first-match result walks the chain one
// cell per cycle, so the answer is the tag of the first entry whose masked
// opcode equals its code, or a miss with tag 0. Each item gives exactly one
// result item. A register item goes from idle straight to the done state,
// while a lookup first walks the result chain down to the last cell. The
// result sits in an output register, so the next item is taken while an
// earlier result is still stalled, as long as the previous result has
// moved into that register. Stored tags keep the low TAG_WIDTH bits of
// action_tag; returned tags are resized to 8 bits.
module masked_priority_opcode_table_core #(
  parameter int TABLE_DEPTH = mpot_pkg::TABLE_DEPTH_DEF,
  parameter int TAG_WIDTH   = mpot_pkg::TAG_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  mpot_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output mpot_pkg::rsp_item_t rsp
);

  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int WALK_W = $clog2(TABLE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  state_t                    state;
  logic [CNT_W-1:0]          count;
  logic [WALK_W-1:0]         walk;
  logic [mpot_pkg::OP_W-1:0] opcode;
  logic                      pend_kind;
  logic                      pend_status;

  logic                      req_take;
  logic                      is_full;
  mpot_pkg::ins_bus_t        ins;
  logic [TAG_WIDTH-1:0]      ins_tag;
  logic                      rsp_free;

  // Chain links; index 0 is the head fed by the insert bus and a miss.
  logic [TABLE_DEPTH:0]      keep_c;
  logic [mpot_pkg::OP_W-1:0] code_c  [TABLE_DEPTH+1];
  logic [mpot_pkg::OP_W-1:0] mask_c  [TABLE_DEPTH+1];
  logic [TAG_WIDTH-1:0]      tag_c   [TABLE_DEPTH+1];
  logic [TABLE_DEPTH:0]      found_c;
  logic [TAG_WIDTH-1:0]      ftag_c  [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0]    occ;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign is_full   = (count >= CNT_W'(TABLE_DEPTH));
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign ins_tag  = TAG_WIDTH'(req.action_tag);
  assign ins.en   = req_take && (req.kind == mpot_pkg::KIND_REGISTER) && !is_full;
  assign ins.code = req.code;
  assign ins.mask = req.mask;

  // Head of the chain: the new entry lands in cell 0 unless cell 0 keeps.
  assign keep_c[0]  = 1'b1;
  assign code_c[0]  = req.code;
  assign mask_c[0]  = req.mask;
  assign tag_c[0]   = ins_tag;
  assign found_c[0] = 1'b0;
  assign ftag_c[0]  = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    // Entries are packed at the front, so a cell holds data below the count.
    assign occ[i] = (count > CNT_W'(i));

    mpot_cell #(
      .TAG_WIDTH (TAG_WIDTH)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .ins            (ins),
      .ins_tag        (ins_tag),
      .occupied       (occ[i]),
      .prev_keep      (keep_c[i]),
      .prev_code      (code_c[i]),
      .prev_mask      (mask_c[i]),
      .prev_tag       (tag_c[i]),
      .opcode         (opcode),
      .prev_found     (found_c[i]),
      .prev_found_tag (ftag_c[i]),
      .keep           (keep_c[i+1]),
      .code           (code_c[i+1]),
      .mask           (mask_c[i+1]),
      .tag            (tag_c[i+1]),
      .found          (found_c[i+1]),
      .found_tag      (ftag_c[i+1])
    );
  end

  // Fill count: advance on every insert that fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ins.en) begin
      count <= count + CNT_W'(1);
    end
  end

  // Hold the lookup opcode and the pending register status.
  always_ff @(posedge clk) begin
    if (req_take) begin
      opcode      <= req.opcode;
      pend_kind   <= req.kind;
      pend_status <= is_full ? mpot_pkg::STATUS_FULL : mpot_pkg::STATUS_OK;
    end
  end

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      walk      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Drop a taken result unless a new one loads in the same cycle.
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_take) begin
            walk  <= '0;
            state <= (req.kind == mpot_pkg::KIND_LOOKUP) ? S_WALK : S_DONE;
          end
        end
        S_WALK: begin
          // Leave the walk once the result has run down to the last cell.
          if (walk == WALK_W'(TABLE_DEPTH - 1)) begin
            state <= S_DONE;
          end else begin
            walk <= walk + WALK_W'(1);
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            if (pend_kind == mpot_pkg::KIND_LOOKUP) begin
              rsp.hit         <= found_c[TABLE_DEPTH];
              rsp.matched_tag <= mpot_pkg::FIELD_TAG_W'(ftag_c[TABLE_DEPTH]);
              rsp.status      <= mpot_pkg::STATUS_OK;
            end else begin
              rsp.hit         <= 1'b0;
              rsp.matched_tag <= '0;
              rsp.status      <= pend_status;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (req_take && req.kind == mpot_pkg::KIND_REGISTER && is_full) |=> $stable(count))
    else $error("full table changed on refused insert");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (req_take && req.kind == mpot_pkg::KIND_REGISTER && !is_full)
      |=> (count == $past(count) + CNT_W'(1)))
    else $error("accepted insert did not grow the table");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.hit) |-> (rsp.matched_tag == '0))
    else $error("miss result carries a tag");

  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.hit) |-> (rsp.status == mpot_pkg::STATUS_OK))
    else $error("hit result flagged as refused");

endmodule
